@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/dpas_pkg.sv @@
package dpas_pkg;

   localparam int ADDR_WIDTH       = 48;
   localparam int TABLE_ENTRIES    = 64;
   localparam int MAX_ACCESS_BYTES = 256;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int LEN_W  = $clog2(MAX_ACCESS_BYTES + 1);

   localparam int PB_W   = 5;
   localparam int LB_W   = 4;
   localparam int PB_MIN = 12;
   localparam int PB_MAX = 30;
   localparam int LB_MIN = 3;
   localparam int LB_MAX = 12;
   localparam int TAG_W  = ADDR_WIDTH - PB_MIN;
   localparam int ROOM_W = LB_MAX + 1;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Register indexes, taken from the address bits above the 8-byte slot.
   localparam logic [1:0] REG_PAGE_BITS = 2'd0;
   localparam logic [1:0] REG_LINE_BITS = 2'd1;
   localparam logic [1:0] REG_PHYS_BASE = 2'd2;

   // Where the table index of an emitted chunk comes from.
   localparam logic [1:0] SRC_CACHE = 2'd0;
   localparam logic [1:0] SRC_SCAN  = 2'd1;
   localparam logic [1:0] SRC_ALLOC = 2'd2;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] vaddr;
      logic [LEN_W-1:0]      byte_count;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] paddr;
      logic [LEN_W-1:0]      chunk_len;
      logic                  last_chunk;
      logic                  status;
   } rsp_type;

   typedef struct packed {
      logic [PB_W-1:0]       page_bits;
      logic [LB_W-1:0]       line_bits;
      logic [ADDR_WIDTH-1:0] phys_base;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic [1:0] idx_src;
      logic       err;
      logic       alloc;
      logic       scan_start;
      logic       scan_run;
   } cmd_type;

   typedef struct packed {
      logic req_nz;
      logic cache_hit;
      logic scan_hit;
      logic scan_done;
      logic table_full;
      logic last;
   } sts_type;

endpackage

@@ rtl/core/demand_paged_address_splitter.sv @@
// An access is taken at the edge where start is high, busy is low and its byte count is
// nonzero. When its page matches the last mapping, its chunks are emitted straight from the
// chunk state. A chunk on another page scans the page table one entry per cycle from the
// table memory read port, then allocates a new entry, or is refused with status set when full.
// Chunks are strobed from an output register; busy stays high until the last is emitted.
// Reset (synchronous, active high) empties the page table at once; results cannot be stalled.
module demand_paged_address_splitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  dpas_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output dpas_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dpas_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dpas_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dpas_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import dpas_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   dpas_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dpas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   dpas_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/dpas_csr.sv @@
module dpas_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dpas_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dpas_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dpas_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output dpas_pkg::cfg_type                 cfg
);
   import dpas_pkg::*;

   logic [PB_W-1:0]       page_bits_ff, page_bits_in;
   logic [LB_W-1:0]       line_bits_ff, line_bits_in;
   logic [ADDR_WIDTH-1:0] phys_base_ff, phys_base_in;
   logic                  wr_en;
   logic [1:0]            reg_sel;
   logic [PB_W-1:0]       pb_eff;
   logic [LB_W-1:0]       lb_eff;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[CSR_ADDR_W-1:3];

   always_comb begin
      page_bits_in = page_bits_ff;
      line_bits_in = line_bits_ff;
      phys_base_in = phys_base_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PAGE_BITS: page_bits_in = pwdata[PB_W-1:0];
            REG_LINE_BITS: line_bits_in = pwdata[LB_W-1:0];
            REG_PHYS_BASE: phys_base_in = pwdata[ADDR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_bits_ff <= PB_W'(PB_MIN);
         line_bits_ff <= LB_W'(6);
         phys_base_ff <= '0;
      end else begin
         page_bits_ff <= page_bits_in;
         line_bits_ff <= line_bits_in;
         phys_base_ff <= phys_base_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PAGE_BITS: prdata = CSR_DATA_W'(page_bits_ff);
         REG_LINE_BITS: prdata = CSR_DATA_W'(line_bits_ff);
         REG_PHYS_BASE: prdata = CSR_DATA_W'(phys_base_ff);
         default:       prdata = '0;
      endcase
   end

   // Out-of-range settings are clamped; the line size can then never exceed the page size.
   always_comb begin
      if (page_bits_ff < PB_W'(PB_MIN))      pb_eff = PB_W'(PB_MIN);
      else if (page_bits_ff > PB_W'(PB_MAX)) pb_eff = PB_W'(PB_MAX);
      else                                   pb_eff = page_bits_ff;
      if (line_bits_ff < LB_W'(LB_MIN))      lb_eff = LB_W'(LB_MIN);
      else if (line_bits_ff > LB_W'(LB_MAX)) lb_eff = LB_W'(LB_MAX);
      else                                   lb_eff = line_bits_ff;
   end

   assign cfg.page_bits = pb_eff;
   assign cfg.line_bits = lb_eff;
   assign cfg.phys_base = phys_base_ff;

endmodule

@@ rtl/core/dpas_ctrl.sv @@
`include "assert_macros.svh"

module dpas_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dpas_pkg::sts_type sts,
   output dpas_pkg::cmd_type cmd
);
   import dpas_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHUNK = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && sts.req_nz) begin
               cmd.load = 1'b1;
               state_in = ST_CHUNK;
            end
         end
         ST_CHUNK: begin
            if (sts.cache_hit) begin
               cmd.emit    = 1'b1;
               cmd.idx_src = SRC_CACHE;
               if (sts.last) state_in = ST_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit) begin
               cmd.emit    = 1'b1;
               cmd.idx_src = SRC_SCAN;
               state_in    = sts.last ? ST_IDLE : ST_CHUNK;
            end else if (sts.scan_done) begin
               cmd.emit    = 1'b1;
               cmd.idx_src = SRC_ALLOC;
               cmd.err     = sts.table_full;
               cmd.alloc   = !sts.table_full;
               state_in    = sts.last ? ST_IDLE : ST_CHUNK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   `ASSERT_NEXT(a_last_to_idle, clock, reset, cmd.emit && sts.last, state_ff == ST_IDLE)
   `ASSERT_IMPL(a_no_alloc_when_full, clock, reset, cmd.alloc, !sts.table_full && !cmd.err)
   `ASSERT_IMPL(a_load_only_idle, clock, reset, cmd.load, !busy && !cmd.emit)

endmodule

@@ rtl/core/dpas_dp.sv @@
`include "assert_macros.svh"

module dpas_dp (
   input  logic              clock,
   input  logic              reset,
   input  dpas_pkg::cfg_type cfg,
   input  dpas_pkg::req_type req_data,
   input  dpas_pkg::cmd_type cmd,
   output dpas_pkg::sts_type sts,
   output logic              rsp_strobe,
   output dpas_pkg::rsp_type rsp_data
);
   import dpas_pkg::*;

   logic [ADDR_WIDTH-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  cache_vld_ff, cache_vld_in;
   logic [TAG_W-1:0]      cache_tag_ff, cache_tag_in;
   logic [IDX_W-1:0]      cache_idx_ff, cache_idx_in;
   logic [CNT_W-1:0]      scan_addr_ff, scan_addr_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [TAG_W-1:0]      rd_data_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rsp_vld_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [TAG_W-1:0]      tag_mem [TABLE_ENTRIES];

   logic                  rd_go;
   logic [TAG_W-1:0]      tag;
   logic [LB_MAX-1:0]     line_mask;
   logic [ROOM_W-1:0]     room;
   logic [LEN_W-1:0]      len;
   logic [ADDR_WIDTH-1:0] page_mask;
   logic [IDX_W-1:0]      idx;
   logic [ADDR_WIDTH-1:0] pa;
   logic [LEN_W-1:0]      req_len;

   // Chunk geometry for the current position.
   always_comb begin
      line_mask = LB_MAX'((ROOM_W'(1) << cfg.line_bits) - ROOM_W'(1));
      room      = (ROOM_W'(1) << cfg.line_bits) - ROOM_W'(cur_ff[LB_MAX-1:0] & line_mask);
      len       = (ROOM_W'(rem_ff) < room) ? rem_ff : room[LEN_W-1:0];
      tag       = TAG_W'(cur_ff >> cfg.page_bits);
      page_mask = (ADDR_WIDTH'(1) << cfg.page_bits) - ADDR_WIDTH'(1);
   end

   always_comb begin
      case (cmd.idx_src)
         SRC_CACHE: idx = cache_idx_ff;
         SRC_SCAN:  idx = rd_idx_ff;
         SRC_ALLOC: idx = cnt_ff[IDX_W-1:0];
         default:   idx = cache_idx_ff;
      endcase
      pa = cfg.phys_base + (ADDR_WIDTH'(idx) << cfg.page_bits) + (cur_ff & page_mask);
   end

   assign req_len = (req_data.byte_count > LEN_W'(MAX_ACCESS_BYTES)) ?
                    LEN_W'(MAX_ACCESS_BYTES) : req_data.byte_count;

   assign rd_go = cmd.scan_run && (scan_addr_ff < cnt_ff);

   always_comb begin
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      cache_vld_in = cache_vld_ff;
      cache_tag_in = cache_tag_ff;
      cache_idx_in = cache_idx_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in    = rd_vld_ff;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         cur_in = req_data.vaddr;
         rem_in = req_len;
      end
      if (cmd.scan_start) begin
         scan_addr_in = '0;
         rd_vld_in    = 1'b0;
      end else if (cmd.scan_run) begin
         rd_vld_in = rd_go;
         if (rd_go) scan_addr_in = scan_addr_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         rsp_in.paddr      = cmd.err ? '0 : pa;
         rsp_in.chunk_len  = len;
         rsp_in.last_chunk = (rem_ff == len);
         rsp_in.status     = cmd.err;
         cur_in            = cur_ff + ADDR_WIDTH'(len);
         rem_in            = rem_ff - len;
         if (!cmd.err) begin
            cache_vld_in = 1'b1;
            cache_tag_in = tag;
            cache_idx_in = idx;
         end
      end
      if (cmd.alloc) cnt_in = cnt_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cache_vld_ff <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         cache_vld_ff <= cache_vld_in;
         scan_addr_ff <= scan_addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_vld_ff   <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rem_ff       <= rem_in;
      cache_tag_ff <= cache_tag_in;
      cache_idx_ff <= cache_idx_in;
      rsp_ff       <= rsp_in;
   end

   // Page table: filled in index order, one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.alloc) tag_mem[cnt_ff[IDX_W-1:0]] <= tag;
   end

   always_ff @(posedge clock) begin
      if (rd_go) begin
         rd_data_ff <= tag_mem[scan_addr_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_addr_ff[IDX_W-1:0];
      end
   end

   assign sts.req_nz     = (req_data.byte_count != '0);
   assign sts.cache_hit  = cache_vld_ff && (cache_tag_ff == tag);
   assign sts.scan_hit   = rd_vld_ff && (rd_data_ff == tag);
   assign sts.scan_done  = !rd_vld_ff && (scan_addr_ff == cnt_ff);
   assign sts.table_full = (cnt_ff == CNT_W'(TABLE_ENTRIES));
   assign sts.last       = (rem_ff == len);

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(TABLE_ENTRIES))
   `ASSERT_IMPL(a_len_nonzero, clock, reset, rsp_vld_ff, rsp_ff.chunk_len != '0)
   `ASSERT_NEXT(a_err_full, clock, reset, cmd.emit && cmd.err, rsp_ff.paddr == '0 && sts.table_full)

endmodule

@@ tb/sv/demand_paged_address_splitter_checker.sv @@
`timescale 1ns / 100ps

module demand_paged_address_splitter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  dpas_pkg::req_type                 req_data,
   input  logic                              rsp_strobe,
   input  dpas_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [dpas_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dpas_pkg::CSR_DATA_W-1:0]   pwdata,
   output int                                failures,
   output int                                outstanding,
   output int                                chunks_checked,
   output int                                chunks_refused
);
   import dpas_pkg::*;

   logic [PB_W-1:0]       cfg_page_bits;
   logic [LB_W-1:0]       cfg_line_bits;
   logic [ADDR_WIDTH-1:0] cfg_phys_base;

   logic [TAG_W-1:0]         page_tag [TABLE_ENTRIES];
   bit [TABLE_ENTRIES-1:0]   tag_live;
   int                       pages_used;

   rsp_type expected_chunks [$];
   int      mismatch_count = 0;
   int      checked_count = 0;
   int      refused_count = 0;

   // Splits one access into line-sized chunks and maps each chunk's page,
   // allocating table entries in order as a real access would.
   function automatic void translate_access(input req_type access);
      int unsigned           pb;
      int unsigned           lb;
      logic [ADDR_WIDTH-1:0] cur;
      int unsigned           remaining;
      int unsigned           room;
      int unsigned           len;
      logic [63:0]           line_mask;
      logic [63:0]           page_mask;
      logic [63:0]           pa;
      logic [TAG_W-1:0]      tag;
      int                    hit;
      rsp_type               chunk;

      pb = cfg_page_bits;
      if (pb < PB_MIN) pb = PB_MIN;
      if (pb > PB_MAX) pb = PB_MAX;
      lb = cfg_line_bits;
      if (lb < LB_MIN) lb = LB_MIN;
      if (lb > LB_MAX) lb = LB_MAX;
      if (lb > pb) lb = pb;
      line_mask = (64'd1 << lb) - 64'd1;
      page_mask = (64'd1 << pb) - 64'd1;
      cur = access.vaddr;
      remaining = access.byte_count;
      if (remaining == 0) return;
      if (remaining > MAX_ACCESS_BYTES) remaining = MAX_ACCESS_BYTES;

      while (remaining > 0) begin
         room = int'(line_mask - (64'(cur) & line_mask) + 64'd1);
         len = (remaining < room) ? remaining : room;
         tag = TAG_W'(cur >> pb);
         hit = -1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tag_live[i] && page_tag[i] == tag) begin
               hit = i;
               break;
            end
         end
         if (hit < 0 && pages_used < TABLE_ENTRIES) begin
            hit = pages_used;
            page_tag[hit] = tag;
            tag_live[hit] = 1'b1;
            pages_used++;
         end
         if (hit >= 0) begin
            pa = 64'(cfg_phys_base) + (64'(hit) << pb) + (64'(cur) & page_mask);
            chunk.paddr = pa[ADDR_WIDTH-1:0];
            chunk.status = 1'b0;
         end else begin
            chunk.paddr = '0;
            chunk.status = 1'b1;
            refused_count++;
         end
         remaining -= len;
         chunk.chunk_len = LEN_W'(len);
         chunk.last_chunk = (remaining == 0);
         expected_chunks.insert(expected_chunks.size(), chunk);
         cur = cur + ADDR_WIDTH'(len);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg_page_bits = 5'd12;
         cfg_line_bits = 4'd6;
         cfg_phys_base = '0;
         tag_live = '0;
         pages_used = 0;
         expected_chunks.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               REG_PAGE_BITS: cfg_page_bits = pwdata[PB_W-1:0];
               REG_LINE_BITS: cfg_line_bits = pwdata[LB_W-1:0];
               REG_PHYS_BASE: cfg_phys_base = pwdata[ADDR_WIDTH-1:0];
               default: ;
            endcase
         end
         if (start && !busy) translate_access(req_data);
         if (rsp_strobe) begin
            if (expected_chunks.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: expected no chunk, got paddr=%h len=%0d last=%b status=%b",
                        $time, rsp_data.paddr, rsp_data.chunk_len, rsp_data.last_chunk,
                        rsp_data.status);
            end else begin
               want = expected_chunks.pop_front();
               checked_count++;
               if (rsp_data.paddr !== want.paddr || rsp_data.chunk_len !== want.chunk_len ||
                   rsp_data.last_chunk !== want.last_chunk ||
                   rsp_data.status !== want.status) begin
                  mismatch_count++;
                  // Fields print as paddr/len/last/status.
                  $display("%0t ns: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                           $time, want.paddr, want.chunk_len, want.last_chunk, want.status,
                           rsp_data.paddr, rsp_data.chunk_len, rsp_data.last_chunk,
                           rsp_data.status);
               end
            end
         end
      end
      failures <= mismatch_count;
      outstanding <= expected_chunks.size();
      chunks_checked <= checked_count;
      chunks_refused <= refused_count;
   end

endmodule

@@ tb/sv/tb_demand_paged_address_splitter.sv @@
`timescale 1ns / 100ps

module tb_demand_paged_address_splitter;
   import dpas_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int failures;
   int outstanding;
   int chunks_checked;
   int chunks_refused;
   int accesses_sent = 0;
   int reg_writes = 0;

   logic [ADDR_WIDTH-1:0] hot_pages [8];

   always #6 clock = ~clock;

   demand_paged_address_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   demand_paged_address_splitter_checker chunk_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .failures       (failures),
      .outstanding    (outstanding),
      .chunks_checked (chunks_checked),
      .chunks_refused (chunks_refused)
   );

   // Every task is entered just after a rising edge and returns just after one.
   task automatic write_reg(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic send_access(input logic [ADDR_WIDTH-1:0] vaddr, input logic [LEN_W-1:0] count);
      req_type beat;
      bit      steady;
      beat.vaddr = vaddr;
      beat.byte_count = count;
      req_data <= beat;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      accesses_sent++;
      steady = (accesses_sent >= 50 && accesses_sent < 90);
      if (!steady && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Waits until every expected chunk is back and the block is idle; the extra
   // cycles are only a margin before the next register writes.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(input int pb, input int lb, input logic [ADDR_WIDTH-1:0] base);
      drain();
      write_reg(REG_PAGE_BITS, CSR_DATA_W'(pb));
      write_reg(REG_LINE_BITS, CSR_DATA_W'(lb));
      write_reg(REG_PHYS_BASE, CSR_DATA_W'(base));
   endtask

   // Most accesses land near a few hot pages so that lookups hit; the rest
   // go anywhere and grow the page table.
   task automatic run_phase(input int pb, input int lb, input logic [ADDR_WIDTH-1:0] base,
                            input int count, input int fresh_pct);
      logic [ADDR_WIDTH-1:0] vaddr;
      logic [LEN_W-1:0]      len;
      int                    pick;
      configure(pb, lb, base);
      repeat (count) begin
         if ($urandom_range(0, 99) < fresh_pct)
            vaddr = ADDR_WIDTH'({$urandom, $urandom});
         else
            vaddr = hot_pages[$urandom_range(0, 7)] + ADDR_WIDTH'($urandom_range(0, 8191));
         pick = $urandom_range(0, 99);
         if (pick < 4)
            len = '0;
         else if (pick < 9)
            len = LEN_W'($urandom_range(257, 511));
         else if (pick < 60)
            len = LEN_W'($urandom_range(1, 64));
         else
            len = LEN_W'($urandom_range(1, 256));
         send_access(vaddr, len);
      end
   endtask

   initial begin
      #25_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      hot_pages[0] = 48'hFFFF_FFFF_E000;
      hot_pages[1] = '0;
      for (int i = 2; i < 8; i++) hot_pages[i] = ADDR_WIDTH'({$urandom, $urandom});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 4 KB pages, 64-byte lines, base zero.
      send_access(48'h0, 9'd1);
      send_access(48'h0, 9'd256);
      send_access(48'h3F, 9'd2);
      send_access(48'hFFFF_FFFF_FFFF, 9'd1);
      send_access(48'hFFFF_FFFF_FFF0, 9'd256);
      send_access(48'h1234_5678_9ABC, 9'd0);
      send_access(48'h1234_5678_9ABC, 9'd511);
      send_access(48'hFFF, 9'd2);
      send_access(48'hAAAA_AAAA_AAAA, 9'h100);
      send_access(48'h5555_5555_5555, 9'h0FF);
      send_access(48'h5555_5555_5000, 9'd64);

      // Register values below and above their ranges saturate.
      configure(0, 15, 48'hFFFF_FFFF_FFFF);
      send_access(48'h5555_5555_5F80, 9'd256);
      send_access(48'h0, 9'd257);
      send_access(48'hFFFF_FFFF_FF00, 9'd256);

      // Eight-byte lines on 1 GB pages give the longest chunk trains.
      configure(31, 0, 48'h0);
      send_access(48'h3FFF_FFFC, 9'd256);
      send_access(48'h7, 9'd256);
      send_access(48'hFFFF_FFFF_FFFD, 9'd256);

      run_phase(12, 6, ADDR_WIDTH'({$urandom, $urandom}), 20, 25);
      run_phase(30, 12, 48'h0, 25, 25);
      run_phase(20, 3, 48'hFFFF_FFFF_F000, 20, 25);
      run_phase($urandom_range(0, 31), $urandom_range(0, 15),
                ADDR_WIDTH'({$urandom, $urandom}), 20, 30);
      // Mostly fresh pages, enough to run the table out of entries.
      run_phase(12, 4, ADDR_WIDTH'({$urandom, $urandom}), 30, 80);
      drain();

      $display("Sent %0d accesses under %0d register writes, from 8-byte lines to 1 GB pages.",
               accesses_sent, reg_writes);
      $display("Checked %0d chunks, %0d of them turned away by a full page table.",
               chunks_checked, chunks_refused);
      if (failures == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
